>>> design/hsv332_pkg.sv
// ----------------------------------------------------------------------------
// hsv332_pkg
// Shared types, sector codes and helpers for the HSV to RGB332 converter.
// ----------------------------------------------------------------------------
package hsv332_pkg;

    // colour sector selected by hue; no sector for hue at the top of range
    typedef enum logic [2:0] {
        SEC_RY   = 3'd0,
        SEC_YG   = 3'd1,
        SEC_GC   = 3'd2,
        SEC_CB   = 3'd3,
        SEC_BM   = 3'd4,
        SEC_MR   = 3'd5,
        SEC_NONE = 3'd6
    } sector_t;

    // stage 1 result: raw bound product and ramp weight
    typedef struct packed {
        logic [7:0]  value;
        logic [15:0] lo_prod;
        sector_t     sector;
        logic [7:0]  weight;
    } s1_t;

    // stage 2 result: bound and span above it
    typedef struct packed {
        logic [7:0] value;
        logic [7:0] lo;
        logic [7:0] span;
        sector_t    sector;
        logic [7:0] weight;
    } s2_t;

    // stage 3 result: raw ramp product
    typedef struct packed {
        logic [7:0]  value;
        logic [7:0]  lo;
        logic [15:0] ramp_prod;
        sector_t     sector;
    } s3_t;

    localparam logic [10:0] H6_STEP = 11'd255;

    // exact floor(p / 255) for p up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [15:0] t;
        t = p + 16'd1 + {8'd0, p[15:8]};
        return t[15:8];
    endfunction

    function automatic logic [7:0] pack332(input logic [7:0] r,
                                           input logic [7:0] g,
                                           input logic [7:0] b);
        return {r[7:5], g[7:5], b[7:6]};
    endfunction

endpackage

>>> design/hsv332_front.sv
// ----------------------------------------------------------------------------
// hsv332_front
// Stage 1: bound product, hue sector and triangular ramp weight.
// ----------------------------------------------------------------------------
module hsv332_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [7:0]        hue,
    input  logic [7:0]        sat,
    input  logic [7:0]        value,
    output logic              dn_valid,
    input  logic              dn_ready,
    output hsv332_pkg::s1_t   dn_data
);

    logic              valid_reg;
    hsv332_pkg::s1_t   data_reg;
    hsv332_pkg::s1_t   data_next;
    logic [10:0]       h6;
    logic [10:0]       ph;
    logic [7:0]        hue_dist;
    hsv332_pkg::sector_t sec;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

    always_comb
    begin
        priority if (h6 >= 11'(6 * hsv332_pkg::H6_STEP))
            sec = hsv332_pkg::SEC_NONE;
        else if (h6 >= 11'(5 * hsv332_pkg::H6_STEP))
            sec = hsv332_pkg::SEC_MR;
        else if (h6 >= 11'(4 * hsv332_pkg::H6_STEP))
            sec = hsv332_pkg::SEC_BM;
        else if (h6 >= 11'(3 * hsv332_pkg::H6_STEP))
            sec = hsv332_pkg::SEC_CB;
        else if (h6 >= 11'(2 * hsv332_pkg::H6_STEP))
            sec = hsv332_pkg::SEC_GC;
        else if (h6 >= hsv332_pkg::H6_STEP)
            sec = hsv332_pkg::SEC_YG;
        else
            sec = hsv332_pkg::SEC_RY;
    end

    // h6 mod 510: sector pairs share one period
    always_comb
    begin
        unique case (sec[2:1])
            2'd0:    ph = h6;
            2'd1:    ph = h6 - 11'(2 * hsv332_pkg::H6_STEP);
            2'd2:    ph = h6 - 11'(4 * hsv332_pkg::H6_STEP);
            default: ph = h6 - 11'(6 * hsv332_pkg::H6_STEP);
        endcase
        if (ph >= hsv332_pkg::H6_STEP)
            hue_dist = 8'(ph - hsv332_pkg::H6_STEP);
        else
            hue_dist = 8'(hsv332_pkg::H6_STEP - ph);
    end

    always_comb
    begin
        data_next.value   = value;
        data_next.lo_prod = {8'd0, value} * {8'd0, 8'd255 - sat};
        data_next.sector  = sec;
        data_next.weight  = 8'd255 - hue_dist;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule

>>> design/hsv332_bound.sv
// ----------------------------------------------------------------------------
// hsv332_bound
// Stage 2: scales the bound product by 1/255 and forms the span above it.
// ----------------------------------------------------------------------------
module hsv332_bound (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsv332_pkg::s1_t   up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output hsv332_pkg::s2_t   dn_data
);

    logic              valid_reg;
    hsv332_pkg::s2_t   data_reg;
    hsv332_pkg::s2_t   data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.value  = up_data.value;
        data_next.lo     = hsv332_pkg::div255(up_data.lo_prod);
        data_next.span   = up_data.value - data_next.lo;
        data_next.sector = up_data.sector;
        data_next.weight = up_data.weight;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule

>>> design/hsv332_ramp.sv
// ----------------------------------------------------------------------------
// hsv332_ramp
// Stage 3: multiplies the span by the ramp weight.
// ----------------------------------------------------------------------------
module hsv332_ramp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsv332_pkg::s2_t   up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output hsv332_pkg::s3_t   dn_data
);

    logic              valid_reg;
    hsv332_pkg::s3_t   data_reg;
    hsv332_pkg::s3_t   data_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb
    begin
        data_next.value     = up_data.value;
        data_next.lo        = up_data.lo;
        data_next.ramp_prod = {8'd0, up_data.span} * {8'd0, up_data.weight};
        data_next.sector    = up_data.sector;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule

>>> design/hsv332_pack.sv
// ----------------------------------------------------------------------------
// hsv332_pack
// Stage 4: ramp scaling, channel assignment per sector and RGB332 packing.
// ----------------------------------------------------------------------------
module hsv332_pack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  hsv332_pkg::s3_t   up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic [7:0]        dn_color
);

    logic        valid_reg;
    logic [7:0]  color_reg;
    logic [7:0]  color_next;
    logic [7:0]  mid;
    logic [7:0]  v;
    logic [7:0]  lo;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_color = color_reg;

    assign v   = up_data.value;
    assign lo  = up_data.lo;
    // x + lo never exceeds value, so 8 bits suffice
    assign mid = hsv332_pkg::div255(up_data.ramp_prod) + lo;

    always_comb
    begin
        unique case (up_data.sector)
            hsv332_pkg::SEC_RY: color_next = hsv332_pkg::pack332(v, mid, lo);
            hsv332_pkg::SEC_YG: color_next = hsv332_pkg::pack332(mid, v, lo);
            hsv332_pkg::SEC_GC: color_next = hsv332_pkg::pack332(lo, v, mid);
            hsv332_pkg::SEC_CB: color_next = hsv332_pkg::pack332(lo, mid, v);
            hsv332_pkg::SEC_BM: color_next = hsv332_pkg::pack332(mid, lo, v);
            hsv332_pkg::SEC_MR: color_next = hsv332_pkg::pack332(v, lo, mid);
            default:            color_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            color_reg <= color_next;
    end

endmodule

>>> design/hsv332_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb332_top
// HSV to packed RGB332 colour converter, four-stage pipeline.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock when the output side is not stalled.
// Each of the four pipeline registers (sector/weight, bound scaling, ramp
// multiply, pack) holds one transaction and frees itself when the stage
// after it takes its data, so back-pressure fills the pipeline bubble by
// bubble and nothing is lost or repeated.
// Hue 255 lies in no sector and yields colour 0.
module hsv_to_rgb332_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] hue_in,
    input  logic [7:0] saturation_in,
    input  logic [7:0] value_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] rgb332_color
);

    logic            v1, v2, v3;
    logic            r2, r3, r4;
    hsv332_pkg::s1_t d1;
    hsv332_pkg::s2_t d2;
    hsv332_pkg::s3_t d3;

    hsv332_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .hue      (hue_in),
        .sat      (saturation_in),
        .value    (value_in),
        .dn_valid (v1),
        .dn_ready (r2),
        .dn_data  (d1)
    );

    hsv332_bound u_bound (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v1),
        .up_ready (r2),
        .up_data  (d1),
        .dn_valid (v2),
        .dn_ready (r3),
        .dn_data  (d2)
    );

    hsv332_ramp u_ramp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v2),
        .up_ready (r3),
        .up_data  (d2),
        .dn_valid (v3),
        .dn_ready (r4),
        .dn_data  (d3)
    );

    hsv332_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v3),
        .up_ready (r4),
        .up_data  (d3),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .dn_color (rgb332_color)
    );

    // a free output side never blocks the input
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

    // input can only stall once a result is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // fixed latency with no back-pressure
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
        |=> out_valid)
        else $error("transaction did not reach output in four cycles");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsv_to_rgb332_top. A directed table comes first,
// then random pixels. The two sides of the valid/ready handshake idle at
// random, the output side holds off once for a long stretch, and each
// transaction out is compared with a colour typed in or predicted when its pixel went in.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PIXELS = 600;
    localparam int QUIET_TAIL    = 100;   // last pixels with no idling
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_AT      = 320;
    localparam int PIPE_DEPTH    = 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        bit         known;      // colour typed in, no prediction
        logic [7:0] color;
    } pixel_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] hue_in;
    logic [7:0] saturation_in;
    logic [7:0] value_in;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] rgb332_color;

    // travel with the pixel being offered
    logic       row_known;
    logic [7:0] row_color;

    logic [7:0] color_q[$];
    int         mismatches;
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         hold_req;
    int         quiet_cycles;

    hsv_to_rgb332_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .hue_in       (hue_in),
        .saturation_in(saturation_in),
        .value_in     (value_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rgb332_color (rgb332_color)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] hsv_color(input logic [7:0] h,
                                             input logic [7:0] s,
                                             input logic [7:0] v);
        logic [15:0] h16, s16, v16;
        logic [15:0] floor_lvl, hue6, fold, hue_dist, ramp;
        logic [7:0]  mid, lo8, red, grn, blu;
        hsv332_pkg::sector_t sec;
        h16       = {8'd0, h};
        s16       = {8'd0, s};
        v16       = {8'd0, v};
        floor_lvl = (v16 * (16'd255 - s16)) / 16'd255;
        lo8       = floor_lvl[7:0];
        hue6      = 16'd6 * h16;
        sec       = hsv332_pkg::sector_t'(3'(hue6 / 16'd255));
        fold      = hue6 % 16'd510;
        hue_dist  = (fold >= 16'd255) ? fold - 16'd255 : 16'd255 - fold;
        ramp      = ((v16 - floor_lvl) * (16'd255 - hue_dist)) / 16'd255;
        mid       = lo8 + ramp[7:0];
        case (sec)
            hsv332_pkg::SEC_RY:
            begin
                red = v;   grn = mid; blu = lo8;
            end
            hsv332_pkg::SEC_YG:
            begin
                red = mid; grn = v;   blu = lo8;
            end
            hsv332_pkg::SEC_GC:
            begin
                red = lo8; grn = v;   blu = mid;
            end
            hsv332_pkg::SEC_CB:
            begin
                red = lo8; grn = mid; blu = v;
            end
            hsv332_pkg::SEC_BM:
            begin
                red = mid; grn = lo8; blu = v;
            end
            hsv332_pkg::SEC_MR:
            begin
                red = v;   grn = lo8; blu = mid;
            end
            default: return 8'd0;
        endcase
        return {red[7:5], grn[7:5], blu[7:6]};
    endfunction

    // mostly uniform, sometimes pinned to the ends of the range
    function automatic logic [7:0] pick_level();
        logic [7:0] ends[4];
        ends = '{8'd0, 8'd1, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0)
            return ends[2'($urandom_range(0, 3))];
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one pixel and return at the edge that takes it
    task automatic offer_pixel(input pixel_row_t row);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        hue_in        <= row.hue;
        saturation_in <= row.sat;
        value_in      <= row.val;
        row_known     <= row.known;
        row_color     <= row.color;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // expectation push and result check, both on pre-edge values
    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                color_q.push_back(row_known ? row_color
                                            : hsv_color(hue_in, saturation_in, value_in));
            if (out_valid && out_ready)
            begin
                if (color_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected transaction out: rgb332_color=%02h",
                                 rgb332_color);
                end
                else
                begin
                    want = color_q.pop_front();
                    if (rgb332_color !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("rgb332_color mismatch: expected %02h, got %02h",
                                     want, rgb332_color);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiving side
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
                hold_req = 1'b0;
            end
            else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // sending side and end of run
    initial
    begin
        pixel_row_t table_rows[$];
        pixel_row_t row;
        int         rates[3];

        rates         = '{0, 10, 35};
        mismatches    = 0;
        quiet_cycles  = 0;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        hue_in        <= 8'd0;
        saturation_in <= 8'd0;
        value_in      <= 8'd0;
        row_known     <= 1'b0;
        row_color     <= 8'd0;

        //           hue     sat     val     known  color
        table_rows = '{
            '{8'd0,   8'd0,   8'd0,   1'b1, 8'h00},  // black
            '{8'd255, 8'd255, 8'd255, 1'b1, 8'h00},  // hue at the top: no sector
            '{8'd255, 8'd0,   8'd0,   1'b1, 8'h00},
            '{8'd255, 8'd128, 8'd200, 1'b1, 8'h00},
            '{8'd0,   8'd255, 8'd255, 1'b1, 8'hE0},  // pure red
            '{8'd0,   8'd0,   8'd255, 1'b1, 8'hFF},  // white
            '{8'd128, 8'd0,   8'd255, 1'b1, 8'hFF},
            '{8'd100, 8'd255, 8'd0,   1'b1, 8'h00},
            '{8'd42,  8'd255, 8'd255, 1'b0, 8'h00},  // sector edges from here
            '{8'd43,  8'd255, 8'd255, 1'b0, 8'h00},
            '{8'd85,  8'd255, 8'd255, 1'b0, 8'h00},
            '{8'd86,  8'd255, 8'd255, 1'b0, 8'h00},
            '{8'd127, 8'd200, 8'd180, 1'b0, 8'h00},
            '{8'd128, 8'd200, 8'd180, 1'b0, 8'h00},
            '{8'd170, 8'd128, 8'd255, 1'b0, 8'h00},
            '{8'd171, 8'd128, 8'd255, 1'b0, 8'h00},
            '{8'd212, 8'd90,  8'd220, 1'b0, 8'h00},
            '{8'd213, 8'd90,  8'd220, 1'b0, 8'h00},
            '{8'd254, 8'd255, 8'd255, 1'b0, 8'h00},
            '{8'd1,   8'd1,   8'd1,   1'b0, 8'h00},
            '{8'd254, 8'd254, 8'd254, 1'b0, 8'h00},
            '{8'd170, 8'd255, 8'd128, 1'b0, 8'h00}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        foreach (table_rows[i])
            offer_pixel(table_rows[i]);

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            if (n >= RANDOM_PIXELS - QUIET_TAIL)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (n % 50 == 0)
            begin
                send_idle_pct = rates[2'($urandom_range(0, 2))];
                recv_idle_pct = rates[2'($urandom_range(0, 2))];
            end
            // long output hold-off while input keeps coming
            if (n == HOLD_AT)
                hold_req = 1'b1;
            // let the pipeline empty completely
            if (n == DRAIN_AT)
            begin
                in_valid <= 1'b0;
                do @(posedge clk); while (color_q.size() != 0);
            end
            row.hue   = pick_level();
            row.sat   = pick_level();
            row.val   = pick_level();
            row.known = 1'b0;
            row.color = 8'd0;
            offer_pixel(row);
        end
        in_valid <= 1'b0;

        while (color_q.size() != 0) @(posedge clk);
        repeat (4 * PIPE_DEPTH) @(posedge clk);

        if (mismatches == 0 && color_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> hsv_to_rgb332_top.f
design/hsv332_pkg.sv
design/hsv332_front.sv
design/hsv332_bound.sv
design/hsv332_ramp.sv
design/hsv332_pack.sv
design/hsv332_top.sv
tb/tb.sv
